// ===== hdl/cag_pkg.sv =====
// ----------------------------------------------------------------------------
// cag_pkg
// Shared types and constants of the cave automaton generator: grid sizes,
// command modes, register indexes, controller states and the control
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cag_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int DIM_W       = 7;
	localparam int LIMIT_W     = 4;
	localparam int GEN_W       = 4;
	localparam int CNT_W       = 4;
	localparam int REG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} cag_mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_DEATH  = 3'd2,
		REG_BIRTH  = 3'd3,
		REG_GENS   = 3'd4
	} cag_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_DO,
		ST_RUN,
		ST_FIN
	} cag_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [LIMIT_W-1:0] death;
		logic [LIMIT_W-1:0] birth;
		logic [GEN_W-1:0]   gens;
	} cag_cfg_t;

	typedef struct packed {
		logic latch;
		logic acc_commit;
		logic run_step;
		logic finish;
	} cag_cmd_t;

	typedef struct packed {
		logic gen_zero;
		logic row_end;
		logic gen_end;
	} cag_stat_t;

endpackage

// ===== hdl/cag_ctrl.sv =====
// ----------------------------------------------------------------------------
// cag_ctrl
// Controller state machine: sequences cell accesses and generation runs
// and issues commands to the datapath.
// ----------------------------------------------------------------------------
module cag_ctrl import cag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  cag_stat_t  stat,
	output cag_cmd_t   cmd,
	output logic       busy
);

	cag_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cag_mode_t'(mode))
						MODE_WRITE, MODE_READ: state_nxt = ST_ACC_RD;
						MODE_RUN:              state_nxt = stat.gen_zero ? ST_FIN : ST_RUN;
						default:               state_nxt = ST_FIN;
					endcase
				end
			end
			ST_ACC_RD: state_nxt = ST_ACC_DO;
			ST_ACC_DO: state_nxt = ST_IDLE;
			ST_RUN: begin
				if (stat.row_end && stat.gen_end) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			ST_ACC_RD: ;
			ST_ACC_DO: begin
				cmd.acc_commit = 1'b1;
				cmd.finish     = 1'b1;
			end
			ST_RUN:  cmd.run_step = 1'b1;
			ST_FIN:  cmd.finish   = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== hdl/cag_datapath.sv =====
// ----------------------------------------------------------------------------
// cag_datapath
// Grid row memory with per-row valid bits, a three-row window for the
// generation update, row and generation counters and the result register.
// ----------------------------------------------------------------------------
module cag_datapath import cag_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cag_cfg_t         cfg,
	input  cag_cmd_t         cmd,
	input  logic [1:0]       mode,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] column,
	input  logic             cell_in,
	output cag_stat_t        stat,
	output logic             done,
	output logic             cell_out,
	output logic             status
);

	localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLUMNS);
	localparam logic [DIM_W-1:0] LAG      = DIM_W'(3);
	localparam logic [DIM_W-1:0] TAIL     = DIM_W'(2);

	// grid storage
	logic [MAX_COLUMNS-1:0] mem_q [MAX_ROWS];
	logic [MAX_ROWS-1:0]    valid_q;
	logic [MAX_COLUMNS-1:0] rdata_s1;
	logic                   rvalid_s1;
	logic [MAX_COLUMNS-1:0] row_data;
	logic [ROW_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [ROW_W-1:0]       wr_addr;
	logic [MAX_COLUMNS-1:0] wr_data;

	// latched command word
	cag_mode_t        mode_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             cell_q;

	// generation window and counters
	logic [MAX_COLUMNS-1:0] prev_q, cur_q, nxt_q;
	logic [DIM_W-1:0]       cnt_q;
	logic [GEN_W-1:0]       gen_q;
	logic [DIM_W-1:0]       cnt_m3;

	logic [DIM_W-1:0]       h_eff, w_eff;
	logic [MAX_COLUMNS-1:0] cmask;
	logic [MAX_COLUMNS-1:0] new_row;
	logic [MAX_COLUMNS+1:0] pad_p, pad_c, pad_n;
	logic                   coord_ok;
	logic                   acc_wr;
	logic                   run_wr;

	// effective grid size
	always_comb begin
		h_eff = (cfg.height > ROWS_MAX) ? ROWS_MAX : cfg.height;
		w_eff = (cfg.width > COLS_MAX) ? COLS_MAX : cfg.width;
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			cmask[c] = (DIM_W'(c) < w_eff);
		end
	end

	assign coord_ok = ({1'b0, row_q} < h_eff) && ({1'b0, col_q} < w_eff);
	assign row_data = rvalid_s1 ? rdata_s1 : '0;
	assign cnt_m3   = cnt_q - LAG;

	// status to the controller
	assign stat.gen_zero = (cfg.gens == '0);
	assign stat.row_end  = (cnt_q == h_eff + TAIL);
	assign stat.gen_end  = (gen_q == cfg.gens - GEN_W'(1));

	// neighbour count and rule per column, outside cells count as walls
	always_comb begin
		logic [CNT_W-1:0] n;
		pad_p = {1'b1, prev_q | ~cmask, 1'b1};
		pad_c = {1'b1, cur_q | ~cmask, 1'b1};
		pad_n = {1'b1, nxt_q | ~cmask, 1'b1};
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			n = CNT_W'(pad_p[c]) + CNT_W'(pad_p[c+1]) + CNT_W'(pad_p[c+2])
				+ CNT_W'(pad_c[c]) + CNT_W'(pad_c[c+2])
				+ CNT_W'(pad_n[c]) + CNT_W'(pad_n[c+1]) + CNT_W'(pad_n[c+2]);
			if (cmask[c]) begin
				new_row[c] = cur_q[c] ? (n >= cfg.death) : (n > cfg.birth);
			end else begin
				new_row[c] = cur_q[c];
			end
		end
	end

	// memory port selection
	always_comb begin
		run_wr  = cmd.run_step && (cnt_q >= LAG) && (cnt_m3 < h_eff);
		acc_wr  = cmd.acc_commit && (mode_q == MODE_WRITE) && coord_ok;
		rd_addr = cmd.run_step ? cnt_q[ROW_W-1:0] : row_q;
		wr_en   = run_wr || acc_wr;
		if (run_wr) begin
			wr_addr = cnt_m3[ROW_W-1:0];
			wr_data = new_row;
		end else begin
			wr_addr = row_q;
			wr_data = (row_data & ~(MAX_COLUMNS'(1) << col_q))
				| (MAX_COLUMNS'(cell_q) << col_q);
		end
	end

	// row memory, registered read
	always_ff @(posedge clk) begin
		rdata_s1 <= mem_q[rd_addr];
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// row valid bits, an unwritten row reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// command word latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= cag_mode_t'(mode);
			row_q  <= row;
			col_q  <= column;
			cell_q <= cell_in;
		end
	end

	// row and generation counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			gen_q <= '0;
		end else if (cmd.latch) begin
			cnt_q <= '0;
			gen_q <= '0;
		end else if (cmd.run_step) begin
			if (stat.row_end) begin
				cnt_q <= '0;
				gen_q <= gen_q + GEN_W'(1);
			end else begin
				cnt_q <= cnt_q + DIM_W'(1);
			end
		end
	end

	// three-row window, rows outside the grid are all wall
	always_ff @(posedge clk) begin
		if (cmd.run_step) begin
			if (cnt_q == '0) begin
				prev_q <= '1;
				cur_q  <= '1;
				nxt_q  <= '1;
			end else begin
				prev_q <= cur_q;
				cur_q  <= nxt_q;
				nxt_q  <= (cnt_q <= h_eff) ? row_data : '1;
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			cell_out <= (mode_q == MODE_READ) && coord_ok && row_data[col_q];
			status   <= ((mode_q == MODE_WRITE) || (mode_q == MODE_READ)) && !coord_ok;
		end
	end

endmodule

// ===== hdl/cave_automaton_generator_core.sv =====
// ----------------------------------------------------------------------------
// cave_automaton_generator_core
// Cellular automaton cave generator: holds a wall/free grid, writes and
// reads single cells and runs a configured number of generations.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+------------------------
//  command  | mode, row, column, cell_in             | start high, busy low
//  result   | cell_out, status                       | done, one cycle
//  config   | cfg_index, cfg_data                    | cfg_write
//
// A cell write or read passes a row read state and a commit state, then registers its result word.
// A run sweeps the grid rows once per generation, G generations over H rows;
// one grid row memory read per cycle paces the row sweep.
// Mode 3 and a run of zero generations go straight to the finish state.
// Reset clears the row valid bits at once, so the grid reads all free
// without a clearing pass. The receiver takes every result word as shown.
// ----------------------------------------------------------------------------
module cave_automaton_generator_core import cag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [ROW_W-1:0]      row,
	input  logic [COL_W-1:0]      column,
	input  logic                  cell_in,
	output logic                  done,
	output logic                  cell_out,
	output logic                  status,
	input  logic                  cfg_write,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cag_cfg_t  cfg_q;
	cag_cmd_t  cmd;
	cag_stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(64);
			cfg_q.height <= DIM_W'(64);
			cfg_q.death  <= LIMIT_W'(3);
			cfg_q.birth  <= LIMIT_W'(4);
			cfg_q.gens   <= GEN_W'(5);
		end else if (cfg_write) begin
			case (cag_reg_t'(cfg_index))
				REG_WIDTH:  cfg_q.width  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[DIM_W-1:0];
				REG_DEATH:  cfg_q.death  <= cfg_data[LIMIT_W-1:0];
				REG_BIRTH:  cfg_q.birth  <= cfg_data[LIMIT_W-1:0];
				REG_GENS:   cfg_q.gens   <= cfg_data[GEN_W-1:0];
				default:    ;
			endcase
		end
	end

	cag_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cag_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.mode     (mode),
		.row      (row),
		.column   (column),
		.cell_in  (cell_in),
		.stat     (stat),
		.done     (done),
		.cell_out (cell_out),
		.status   (status)
	);

`ifndef SYNTH
	// an accepted word always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result word only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without preceding work");

	// a wall read never carries an error status
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && cell_out |-> !status)
		else $error("cell value shown with error status");
`endif

endmodule

// ===== tb/cave_automaton_generator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cave_automaton_generator_checker
// Watches the command, config and result channels of the cave generator,
// keeps its own copy of the grid and registers, works out the answer of
// every accepted command and compares each result word against it.
// ----------------------------------------------------------------------------
module cave_automaton_generator_checker import cag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [1:0]            mode,
	input  logic [ROW_W-1:0]      row,
	input  logic [COL_W-1:0]      column,
	input  logic                  cell_in,
	input  logic                  done,
	input  logic                  cell_out,
	input  logic                  status,
	input  logic                  cfg_write,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    error_count,
	output int                    words_pending
);

	typedef struct packed {
		logic cell_out;
		logic status;
	} cave_answer_t;

	// mirrored grid, registers and answers still owed by the block
	logic [MAX_COLUMNS-1:0] wall_rows [MAX_ROWS];
	cag_cfg_t               cave_cfg;
	cave_answer_t           awaited_answers [$];
	int                     faults = 0;

	// cells beyond the active area count as walls
	function automatic logic wall_or_edge(int r, int c, int h, int w);
		if (r < 0 || c < 0 || r >= h || c >= w)
			return 1'b1;
		return wall_rows[r][c];
	endfunction

	// one synchronous generation over the h x w area
	task automatic evolve_cave(int h, int w);
		logic [MAX_COLUMNS-1:0] fresh [MAX_ROWS];
		int                     wall_count;
		for (int r = 0; r < h; r++) begin
			fresh[r] = wall_rows[r];
			for (int c = 0; c < w; c++) begin
				wall_count = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							wall_count += wall_or_edge(r + dr, c + dc, h, w);
				if (wall_rows[r][c])
					fresh[r][c] = (wall_count >= cave_cfg.death);
				else
					fresh[r][c] = (wall_count > cave_cfg.birth);
			end
		end
		for (int r = 0; r < h; r++)
			wall_rows[r] = fresh[r];
	endtask

	// update the mirrored grid for one command and form its answer
	task automatic apply_command(input cag_mode_t m, input int r, input int c,
			input logic v, output cave_answer_t answer);
		int h;
		int w;
		h = (cave_cfg.height > MAX_ROWS) ? MAX_ROWS : int'(cave_cfg.height);
		w = (cave_cfg.width > MAX_COLUMNS) ? MAX_COLUMNS : int'(cave_cfg.width);
		answer = '0;
		case (m)
			MODE_WRITE, MODE_READ: begin
				if (r >= h || c >= w)
					answer.status = 1'b1;
				else if (m == MODE_WRITE)
					wall_rows[r][c] = v;
				else
					answer.cell_out = wall_rows[r][c];
			end
			MODE_RUN: begin
				for (int g = 0; g < int'(cave_cfg.gens); g++)
					evolve_cave(h, w);
			end
			default: ;
		endcase
	endtask

	task automatic store_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_WIDTH:  cave_cfg.width  = data;
			REG_HEIGHT: cave_cfg.height = data;
			REG_DEATH:  cave_cfg.death  = data[LIMIT_W-1:0];
			REG_BIRTH:  cave_cfg.birth  = data[LIMIT_W-1:0];
			REG_GENS:   cave_cfg.gens   = data[GEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic note_fault(string what, cave_answer_t want, cave_answer_t seen);
		faults++;
		if (faults <= 10)
			$display("%0t: %s: expected cell_out %0b status %0b, got cell_out %0b status %0b",
				$realtime, what, want.cell_out, want.status, seen.cell_out, seen.status);
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin : watch
		cave_answer_t seen;
		cave_answer_t want;
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++)
				wall_rows[r] = '0;
			cave_cfg.width  = 7'd64;
			cave_cfg.height = 7'd64;
			cave_cfg.death  = 4'd3;
			cave_cfg.birth  = 4'd4;
			cave_cfg.gens   = 4'd5;
			awaited_answers.delete();
			error_count   <= 0;
			words_pending <= 0;
		end else begin
			// result word against the oldest answer
			if (done) begin
				seen.cell_out = cell_out;
				seen.status   = status;
				if (awaited_answers.size() == 0) begin
					note_fault("result word with no command outstanding", '0, seen);
				end else begin
					want = awaited_answers.pop_front();
					if (want != seen)
						note_fault("result word mismatch", want, seen);
				end
			end
			if (cfg_write)
				store_register(cfg_index, cfg_data);
			// accepted command word
			if (start && !busy) begin
				apply_command(cag_mode_t'(mode), int'(row), int'(column), cell_in, want);
				awaited_answers.push_back(want);
			end
			error_count   <= faults;
			words_pending <= awaited_answers.size();
		end
	end

endmodule

// ===== tb/cave_automaton_generator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cave_automaton_generator_core_tb
// Drives cell writes, reads and generation runs into the cave generator
// across many grid sizes and limits, with random sender gaps, and lets the
// checker judge every result word.
// ----------------------------------------------------------------------------
module cave_automaton_generator_core_tb;
	import cag_pkg::*;

	localparam int TOTAL_ITEMS  = 650;
	localparam int PHASE_ITEMS  = 45;
	localparam int LIMIT_CYCLES = 2_000_000;

	// indexes with no register behind them
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            mode;
	logic [ROW_W-1:0]      row;
	logic [COL_W-1:0]      column;
	logic                  cell_in;
	logic                  done;
	logic                  cell_out;
	logic                  status;
	logic                  cfg_write;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    error_count;
	int                    words_pending;

	int items_sent  = 0;
	int idle_pct    = 0;
	int cur_w       = 64;
	int cur_h       = 64;
	int cycle_count = 0;

	cave_automaton_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.row       (row),
		.column    (column),
		.cell_in   (cell_in),
		.done      (done),
		.cell_out  (cell_out),
		.status    (status),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cave_automaton_generator_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.row           (row),
		.column        (column),
		.cell_in       (cell_in),
		.done          (done),
		.cell_out      (cell_out),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.words_pending (words_pending)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("cave_automaton_generator_core verification failed");
			$finish;
		end
	end

	// one command word, with an optional gap in front
	task automatic issue(cag_mode_t m, int r, int c, logic v);
		if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start   <= 1'b1;
		mode    <= m;
		row     <= ROW_W'(r);
		column  <= COL_W'(c);
		cell_in <= v;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// wait until every owed result word is back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [REG_IDX_W-1:0] idx, int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic configure(int w, int h, int d, int b, int g);
		set_reg(REG_WIDTH, w);
		set_reg(REG_HEIGHT, h);
		set_reg(REG_DEATH, d);
		set_reg(REG_BIRTH, b);
		set_reg(REG_GENS, g);
		cfg_write <= 1'b0;
		cur_w = (w > MAX_COLUMNS) ? MAX_COLUMNS : w;
		cur_h = (h > MAX_ROWS) ? MAX_ROWS : h;
	endtask

	function automatic int pick_row();
		return (cur_h > 0) ? $urandom_range(cur_h - 1, 0) : $urandom_range(63, 0);
	endfunction

	function automatic int pick_col();
		return (cur_w > 0) ? $urandom_range(cur_w - 1, 0) : $urandom_range(63, 0);
	endfunction

	function automatic int pick_size();
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 70) return $urandom_range(12, 1);
		if (sel < 80) return $urandom_range(63, 13);
		if (sel < 88) return 64;
		if (sel < 94) return $urandom_range(127, 65);
		return 0;
	endfunction

	function automatic int pick_limit();
		return ($urandom_range(99, 0) < 80) ? $urandom_range(6, 2) : $urandom_range(15, 0);
	endfunction

	// random phase: writes, reads and runs with some noise mixed in
	task automatic random_phase(int phase);
		int w;
		int h;
		int g;
		int sel;
		case (phase % 4)
			0: idle_pct = 0;
			1: idle_pct = 56;
			2: idle_pct = 0;
			default: idle_pct = 19;
		endcase
		case (phase)
			0: configure(1, 1, 0, 0, 15);
			1: configure(64, 64, 15, 15, 15);
			2: configure(3, 64, 4, 3, 15);
			default: begin
				w = pick_size();
				h = pick_size();
				g = (w * h > 256) ? $urandom_range(3, 0) : $urandom_range(15, 0);
				configure(w, h, pick_limit(), pick_limit(), g);
			end
		endcase
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			sel = $urandom_range(99, 0);
			if (sel < 45)
				issue(MODE_WRITE, pick_row(), pick_col(), $urandom_range(99, 0) < 45);
			else if (sel < 70)
				issue(MODE_READ, pick_row(), pick_col(), 1'($urandom_range(1, 0)));
			else if (sel < 80)
				issue(MODE_RUN, $urandom_range(63, 0), $urandom_range(63, 0),
					1'($urandom_range(1, 0)));
			else if (sel < 90)
				issue(($urandom_range(1, 0) != 0) ? MODE_WRITE : MODE_READ,
					$urandom_range(63, 0), $urandom_range(63, 0),
					1'($urandom_range(1, 0)));
			else
				issue(MODE_NONE, $urandom_range(63, 0), $urandom_range(63, 0),
					1'($urandom_range(1, 0)));
		end
		settle();
	endtask

	// stimulus and verdict
	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		mode      <= MODE_WRITE;
		row       <= '0;
		column    <= '0;
		cell_in   <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the full grid at reset settings, unused mode
		issue(MODE_READ, 0, 0, 1'b0);
		issue(MODE_WRITE, 0, 0, 1'b1);
		issue(MODE_WRITE, 63, 63, 1'b1);
		issue(MODE_WRITE, 0, 63, 1'b1);
		issue(MODE_WRITE, 63, 0, 1'b1);
		issue(MODE_READ, 63, 63, 1'b0);
		issue(MODE_READ, 0, 63, 1'b0);
		issue(MODE_NONE, 63, 63, 1'b1);
		issue(MODE_WRITE, 63, 0, 1'b0);
		issue(MODE_READ, 63, 0, 1'b1);
		settle();

		// small area, coordinates outside it, run leaves outer cells alone
		configure(4, 3, 3, 4, 5);
		issue(MODE_WRITE, 2, 3, 1'b1);
		issue(MODE_WRITE, 3, 0, 1'b1);
		issue(MODE_READ, 0, 4, 1'b0);
		issue(MODE_RUN, 0, 0, 1'b0);
		issue(MODE_READ, 1, 1, 1'b0);
		settle();

		// empty area
		configure(0, 3, 3, 4, 5);
		issue(MODE_WRITE, 0, 0, 1'b1);
		issue(MODE_RUN, 0, 0, 1'b0);
		issue(MODE_READ, 0, 0, 1'b0);
		settle();

		// oversize area, walls all die, no births
		configure(127, 127, 9, 8, 2);
		issue(MODE_RUN, 63, 63, 1'b1);
		issue(MODE_READ, 63, 63, 1'b0);
		settle();

		// spare register indexes ignored, zero generations
		set_reg(REG_SPARE_LO, 7'h55);
		set_reg(REG_SPARE_HI, 7'h2a);
		configure(64, 64, 3, 4, 0);
		issue(MODE_WRITE, 10, 20, 1'b1);
		issue(MODE_RUN, 0, 0, 1'b0);
		issue(MODE_READ, 10, 20, 1'b0);
		settle();

		// birth limit zero: a free cell is born only next to a wall or the edge
		configure(5, 5, 0, 0, 1);
		issue(MODE_RUN, 0, 0, 1'b0);
		issue(MODE_READ, 2, 2, 1'b0);
		settle();

		for (int phase = 0; items_sent < TOTAL_ITEMS; phase++)
			random_phase(phase);

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("cave_automaton_generator_core verification clean");
		else
			$display("cave_automaton_generator_core verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cag_pkg.sv
hdl/cag_ctrl.sv
hdl/cag_datapath.sv
hdl/cave_automaton_generator_core.sv
tb/cave_automaton_generator_checker.sv
tb/cave_automaton_generator_core_tb.sv
